// ===== design/br1_pkg.sv =====
package br1_pkg;

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_REP  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic        MODE_RESET   = 1'b1;
  localparam logic [15:0] WIDTH_RESET  = 16'd320;
  localparam logic [15:0] HEIGHT_RESET = 16'd200;

  typedef struct packed {
    logic        mode;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [7:0]  run_length;
    logic [15:0] start_column;
    logic [15:0] line_index;
    logic        end_of_line;
    logic        end_of_image;
    logic        overrun;
  } out_item_t;

endpackage

// ===== design/br1_if.sv =====
interface br1_in_if;
  import br1_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface br1_out_if;
  import br1_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_value;
  logic [7:0]  run_length;
  logic [15:0] start_column;
  logic [15:0] line_index;
  logic        end_of_line;
  logic        end_of_image;
  logic        overrun;
  modport source (output valid, output pixel_value, output run_length, output start_column,
                  output line_index, output end_of_line, output end_of_image,
                  output overrun, input ready);
  modport sink (input valid, input pixel_value, input run_length, input start_column,
                input line_index, input end_of_line, input end_of_image,
                input overrun, output ready);
endinterface

interface br1_cfg_if;
  import br1_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/br1_cfg_regs.sv =====
module br1_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  logic [1:0]    index_i,
  input  logic [15:0]   wdata_i,
  output br1_pkg::cfg_t cfg_o
);
  import br1_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_RESET;
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
    end else if (wr_i) begin
      unique case (index_i)
        CFG_MODE:   cfg_q.mode   <= wdata_i[0];
        CFG_WIDTH:  cfg_q.width  <= wdata_i;
        CFG_HEIGHT: cfg_q.height <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== design/br1_step.sv =====
module br1_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  br1_pkg::cfg_t      cfg_i,
  input  logic               accept_i,
  input  br1_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output br1_pkg::out_item_t res_o
);
  import br1_pkg::*;

  logic [1:0]  phase_q, phase_d, ph;
  logic [7:0]  rem_q, rem_d, rem, rem_dec;
  logic [15:0] col_q, col_d, col;
  logic [15:0] row_q, row_d, row;
  logic        done_q, done_d, done;

  logic        emit;
  logic [7:0]  len;
  logic        more;
  logic [15:0] room;
  logic [15:0] n;
  logic        over;
  logic        eol;
  logic        eoi;
  logic [7:0]  b;
  logic        in_skip;

  always_comb begin
    b       = item_i.data_byte;
    ph      = item_i.restart ? PH_CMD : phase_q;
    rem     = item_i.restart ? 8'd0 : rem_q;
    col     = item_i.restart ? 16'd0 : col_q;
    row     = item_i.restart ? 16'd0 : row_q;
    done    = item_i.restart ? 1'b0 : done_q;
    rem_dec = (rem != 8'd0) ? rem - 8'd1 : 8'd0;
    in_skip = (ph == PH_SKIP);

    emit = !done && !in_skip && (!cfg_i.mode || ph == PH_LIT || ph == PH_REP);
    len  = (cfg_i.mode && ph == PH_REP && rem != 8'd0) ? rem : 8'd1;
    more = cfg_i.mode && ph == PH_LIT && rem_dec != 8'd0;

    room = (col < cfg_i.width) ? cfg_i.width - col : 16'd1;
    over = {8'd0, len} > room;
    n    = over ? room : {8'd0, len};
    eol  = (n == room);
    if (eol && more) begin
      over = 1'b1;
    end
    eoi = eol && ({1'b0, row} + 17'd1 >= {1'b0, cfg_i.height});

    phase_d = ph;
    rem_d   = rem;
    col_d   = col;
    row_d   = row;
    done_d  = done;

    if (!done) begin
      if (in_skip) begin
        rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_d = PH_CMD;
        end
      end else if (!cfg_i.mode) begin
        phase_d = PH_CMD;
        rem_d   = 8'd0;
        if (eol && !eoi && cfg_i.width[0]) begin
          phase_d = PH_SKIP;
          rem_d   = 8'd1;
        end
      end else begin
        case (ph)
          PH_CMD: begin
            if (!b[7]) begin
              phase_d = PH_LIT;
              rem_d   = b + 8'd1;
            end else if (b != 8'h80) begin
              phase_d = PH_REP;
              rem_d   = 8'(9'd257 - {1'b0, b});
            end
          end
          PH_LIT: begin
            rem_d = rem_dec;
            if (rem_dec == 8'd0) begin
              phase_d = PH_CMD;
            end else if (eol) begin
              phase_d = PH_SKIP;
            end
          end
          default: begin
            phase_d = PH_CMD;
            rem_d   = 8'd0;
          end
        endcase
      end

      if (emit) begin
        if (eol) begin
          col_d = 16'd0;
          if (eoi) begin
            done_d = 1'b1;
          end else begin
            row_d = row + 16'd1;
          end
        end else begin
          col_d = col + n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      rem_q   <= 8'd0;
      col_q   <= 16'd0;
      row_q   <= 16'd0;
      done_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

  assign res_valid_o        = accept_i && emit;
  assign res_o.pixel_value  = b;
  assign res_o.run_length   = n[7:0];
  assign res_o.start_column = col;
  assign res_o.line_index   = row;
  assign res_o.end_of_line  = eol;
  assign res_o.end_of_image = eoi;
  assign res_o.overrun      = over;
endmodule

// ===== design/br1_out_buf.sv =====
module br1_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  br1_pkg::out_item_t item_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output br1_pkg::out_item_t item_o
);
  import br1_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_q;
  out_item_t skid_q;
  logic      pop;

  assign pop = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= item_i;
      end else begin
        out_q <= item_i;
      end
    end
  end

  assign space_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign item_o  = out_q;
endmodule

// ===== design/byterun1_line_decoder_core.sv =====
// Channel  Direction  Transfer carries
// in_i     sink       one body byte and its restart mark
// out_o    source     one decoded pixel or run with position and end marks
// cfg_i    sink       register index and write data
//
// Takes one byte per cycle while the output buffer has room; results are registered.
// The decode state updates in a single pass of logic, and a two-entry output
// buffer holds results, so input stalls only when both entries are full.
// Reset clears the decode state and loads the register reset values.
// Configuration writes are always accepted.
module byterun1_line_decoder_core (
  input  logic clk_i,
  input  logic rst_ni,
  br1_in_if.sink    in_i,
  br1_out_if.source out_o,
  br1_cfg_if.sink   cfg_i
);
  import br1_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t res;
  out_item_t res_buf;
  logic      accept;
  logic      res_valid;
  logic      space;

  assign cfg_i.ready    = 1'b1;
  assign item.data_byte = in_i.data_byte;
  assign item.restart   = in_i.restart;
  assign in_i.ready     = space;
  assign accept         = in_i.valid && space;

  br1_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_i.valid),
    .index_i (cfg_i.index),
    .wdata_i (cfg_i.wdata),
    .cfg_o   (cfg)
  );

  br1_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  br1_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .item_i  (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .item_o  (res_buf)
  );

  assign out_o.pixel_value  = res_buf.pixel_value;
  assign out_o.run_length   = res_buf.run_length;
  assign out_o.start_column = res_buf.start_column;
  assign out_o.line_index   = res_buf.line_index;
  assign out_o.end_of_line  = res_buf.end_of_line;
  assign out_o.end_of_image = res_buf.end_of_image;
  assign out_o.overrun      = res_buf.overrun;
endmodule

// ===== tb/testbench.sv =====
import br1_pkg::*;

class run_checker;
  out_item_t   runs_due[$];
  int          mismatches;
  int          run_count;
  logic        mode;
  logic [15:0] width;
  logic [15:0] height;
  logic [1:0]  phase;
  logic [7:0]  remaining;
  logic [15:0] column;
  logic [15:0] row;
  logic        image_done;

  function new();
    mismatches = 0;
    run_count = 0;
    mode = MODE_RESET;
    width = WIDTH_RESET;
    height = HEIGHT_RESET;
    restart_image();
  endfunction

  function void restart_image();
    phase = PH_CMD;
    remaining = 8'd0;
    column = 16'd0;
    row = 16'd0;
    image_done = 1'b0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] value);
    case (idx)
      CFG_MODE: begin
        mode = value[0];
      end
      CFG_WIDTH: begin
        width = value;
      end
      CFG_HEIGHT: begin
        height = value;
      end
      default: begin
      end
    endcase
  endfunction

  // Clips the run to the room left in the line and advances the position.
  function bit add_run(logic [7:0] value, int unsigned len, bit more);
    int unsigned room;
    int unsigned n;
    bit          over;
    bit          eol;
    bit          eoi;
    out_item_t   run;
    room = (int'(column) < int'(width)) ? int'(width) - int'(column) : 1;
    n = len;
    over = 1'b0;
    if (n > room) begin
      n = room;
      over = 1'b1;
    end
    eol = (n == room);
    if (eol && more) begin
      over = 1'b1;
    end
    eoi = eol && (int'(row) + 1 >= int'(height));
    run.pixel_value = value;
    run.run_length = 8'(n);
    run.start_column = column;
    run.line_index = row;
    run.end_of_line = eol;
    run.end_of_image = eoi;
    run.overrun = over;
    runs_due.push_back(run);
    if (eol) begin
      column = 16'd0;
      if (eoi) begin
        image_done = 1'b1;
      end else begin
        row = row + 16'd1;
      end
    end else begin
      column = column + 16'(n);
    end
    return eol;
  endfunction

  function void take_byte(logic [7:0] b, logic restart);
    bit          eol;
    int unsigned len;
    if (restart) begin
      restart_image();
    end
    if (image_done) begin
      return;
    end
    if (phase == PH_SKIP) begin
      if (remaining > 0) begin
        remaining = remaining - 8'd1;
      end
      if (remaining == 0) begin
        phase = PH_CMD;
      end
      return;
    end
    if (!mode) begin
      phase = PH_CMD;
      remaining = 8'd0;
      eol = add_run(b, 1, 1'b0);
      if (eol && !image_done && width[0]) begin
        phase = PH_SKIP;
        remaining = 8'd1;
      end
      return;
    end
    case (phase)
      PH_CMD: begin
        if (b < 8'd128) begin
          phase = PH_LIT;
          remaining = b + 8'd1;
        end else if (b > 8'd128) begin
          phase = PH_REP;
          remaining = 8'(257 - int'(b));
        end
      end
      PH_LIT: begin
        if (remaining > 0) begin
          remaining = remaining - 8'd1;
        end
        eol = add_run(b, 1, remaining > 0);
        if (remaining == 0) begin
          phase = PH_CMD;
        end else if (eol) begin
          phase = PH_SKIP;
        end
      end
      default: begin
        len = (remaining != 0) ? int'(remaining) : 1;
        phase = PH_CMD;
        remaining = 8'd0;
        void'(add_run(b, len, 1'b0));
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 100) begin
      $display("MISMATCH run %0d: %s", run_count, msg);
    end
    mismatches++;
  endtask

  task check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task check_run(out_item_t got);
    out_item_t want;
    run_count++;
    if (runs_due.size() == 0) begin
      report_mismatch($sformatf("unexpected run %p", got));
      return;
    end
    want = runs_due.pop_front();
    check_field("pixel_value", 16'(got.pixel_value), 16'(want.pixel_value));
    check_field("run_length", 16'(got.run_length), 16'(want.run_length));
    check_field("start_column", got.start_column, want.start_column);
    check_field("line_index", got.line_index, want.line_index);
    check_field("end_of_line", 16'(got.end_of_line), 16'(want.end_of_line));
    check_field("end_of_image", 16'(got.end_of_image), 16'(want.end_of_image));
    check_field("overrun", 16'(got.overrun), 16'(want.overrun));
  endtask
endclass

module testbench;
  localparam int TOTAL_ITEMS    = 1120;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;

  br1_in_if  in_bus ();
  br1_out_if out_bus ();
  br1_cfg_if cfg_bus ();

  byterun1_line_decoder_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  run_checker chk = new();
  bit tx_idle;
  bit rx_idle;
  bit hold_rx;
  bit restart_next;
  int sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (chk.runs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    chk.set_reg(idx, value);
  endtask

  task automatic configure(input logic m, input logic [15:0] w, input logic [15:0] h);
    settle();
    write_reg(CFG_MODE, 16'(m));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.restart <= rs;
    do @(posedge clk_i); while (!in_bus.ready);
    chk.take_byte(b, rs);
    sent++;
  endtask

  task automatic send_body(input logic [7:0] b);
    logic rs;
    rs = restart_next || ($urandom_range(0, 99) == 0);
    restart_next = 1'b0;
    send_byte(b, rs);
  endtask

  task automatic send_coded(input int unsigned pixels);
    int unsigned covered;
    int unsigned len;
    int unsigned k;
    int          kind;
    covered = 0;
    while (covered < pixels) begin
      kind = $urandom_range(0, 19);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      if (kind == 0) begin
        send_body(8'h80);
      end else if (kind == 1) begin
        send_body(8'($urandom));
      end else if (kind < 11) begin
        send_body(8'(len - 1));
        for (k = 0; k < len; k++) send_body(8'($urandom));
        covered += len;
      end else begin
        if (len < 2) len = 2;
        send_body(8'(257 - len));
        send_body(8'($urandom));
        covered += len;
      end
    end
  endtask

  task automatic send_raw(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_body(8'($urandom));
  endtask

  initial begin
    int            wait_cycles;
    out_item_t     got;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        wait_cycles = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      got.pixel_value = out_bus.pixel_value;
      got.run_length = out_bus.run_length;
      got.start_column = out_bus.start_column;
      got.line_index = out_bus.line_index;
      got.end_of_line = out_bus.end_of_line;
      got.end_of_image = out_bus.end_of_image;
      got.overrun = out_bus.overrun;
      chk.check_run(got);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          phase_no;
    int          sel;
    logic        m;
    logic [15:0] w;
    logic [15:0] h;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned budget;
    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data_byte <= 8'd0;
    in_bus.restart <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_MODE;
    cfg_bus.wdata <= 16'd0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_rx = 1'b0;
    restart_next = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // Register reset values: no-op, literal, longest repeat and shortest repeat.
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);

    // Literal and repeat clipped at the line end, bytes after the image, restart.
    configure(1'b1, 16'd3, 16'd2);
    send_byte(8'h04, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h83, 1'b1);
    send_byte(8'h99, 1'b0);

    // Uncompressed lines of odd width carry a pad byte.
    configure(1'b0, 16'd3, 16'd2);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);

    phase_no = 0;
    while (sent < TOTAL_ITEMS) begin
      m = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 15);
      w = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd1 : (sel == 2) ? 16'hFFFF :
          (sel == 3) ? 16'($urandom_range(17, 300)) : 16'($urandom_range(1, 16));
      sel = $urandom_range(0, 9);
      h = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
      sel = $urandom_range(0, 3);
      tx_idle = sel[0];
      rx_idle = sel[1];
      case (phase_no)
        0: begin
          w = 16'hFFFF;
          h = 16'hFFFF;
        end
        1: begin
          w = 16'd0;
          h = 16'd0;
        end
        2: begin
          m = 1'b0;
          w = 16'd16;
          h = 16'd4;
          tx_idle = 1'b0;
          hold_rx = 1'b1;
        end
        4: begin
          w = 16'd1;
          h = 16'd1;
        end
        default: begin
        end
      endcase
      w_eff = (w == 0) ? 1 : int'(w);
      h_eff = (h == 0) ? 1 : int'(h);
      budget = w_eff * h_eff;
      if (budget > 64) budget = $urandom_range(16, 64);
      configure(m, w, h);
      restart_next = 1'b1;
      if (m) send_coded(budget);
      else send_raw(budget + h_eff);
      if ($urandom_range(0, 3) == 0) begin
        // Switch mode and width without a restart, sometimes after a lone command.
        if ($urandom_range(0, 1) == 0) send_body(8'($urandom));
        m = !m;
        configure(m, 16'($urandom_range(1, 12)), h);
        if (m) send_coded(24);
        else send_raw(24);
      end
      phase_no++;
    end

    settle();
    if (chk.runs_due.size() != 0) begin
      chk.report_mismatch($sformatf("%0d runs never arrived", chk.runs_due.size()));
    end
    if (chk.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
